>>> sv/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Each macro expands to one labeled concurrent assertion with an error report.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// The expression must hold in every cycle out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`endif

>>> sv/accm_pkg.sv
// Shared types, constants and helper functions for the column conservation mark unit.
// Used by accm_group_lookup and the top level; depends on nothing else.
package accm_pkg;

    localparam int unsigned LETTERS = 26;
    localparam int unsigned STRONG_GROUPS = 9;
    localparam int unsigned WEAK_GROUPS = 11;

    typedef enum logic [1:0] {
        MARK_BLANK = 2'd0,
        MARK_STAR  = 2'd1,
        MARK_COLON = 2'd2,
        MARK_DOT   = 2'd3
    } mark_t;

    typedef enum logic [1:0] {
        CFG_NUCLEOTIDE_MODE   = 2'd0,
        CFG_EXTENDED_ALPHABET = 2'd1,
        CFG_VALID_LETTER_MASK = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [STRONG_GROUPS-1:0] strong_set;
        logic [WEAK_GROUPS-1:0]   weak_set;
    } accm_groups_t;

    localparam logic [7:0] CHAR_GAP     = 8'h2D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [LETTERS-1:0] VALID_MASK_RESET = 26'd24100349;

    // Group membership as letter masks, bit n standing for letter A plus n.
    localparam logic [LETTERS-1:0] PROT_STRONG [STRONG_GROUPS] = '{
        26'h00C0001,  // STA
        26'h0012410,  // NEQK
        26'h0012480,  // NHQK
        26'h0012018,  // NDEQ
        26'h0030480,  // QHRK
        26'h0201900,  // MILV
        26'h0001920,  // MILF
        26'h1000080,  // HY
        26'h1400020   // FYW
    };

    localparam logic [LETTERS-1:0] PROT_WEAK [WEAK_GROUPS] = '{
        26'h0040005,  // CSA
        26'h0280001,  // ATV
        26'h0040041,  // SAG
        26'h00C2400,  // STNK
        26'h00C8001,  // STPA
        26'h0042048,  // SGND
        26'h0052418,  // SNDEQK
        26'h0012498,  // NDEQHK
        26'h0032490,  // NEQHRK
        26'h0201920,  // FVLIM
        26'h10000A0   // HFY
    };

    localparam logic [LETTERS-1:0] NUC_TU = 26'h0180000;
    localparam logic [LETTERS-1:0] NUC_AG = 26'h0000041;
    localparam logic [LETTERS-1:0] NUC_CT = 26'h0080004;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        logic [7:0] result;
        result = c;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            result = c - CASE_OFFSET;
        end
        return result;
    endfunction

    // One-hot letter position of an uppercase character, zero for a non-letter.
    function automatic logic [LETTERS-1:0] letter_onehot(input logic [7:0] u);
        logic [7:0]         diff;
        logic [LETTERS-1:0] result;
        diff   = u - CHAR_UPPER_A;
        result = '0;
        if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z) begin
            result = LETTERS'(1) << diff[4:0];
        end
        return result;
    endfunction

endpackage

>>> sv/accm_group_lookup.sv
// Group membership lookup: which strong and weaker groups hold one letter.
// Depends on accm_pkg for the group letter masks and the result struct.
module accm_group_lookup
(
    input  logic [accm_pkg::LETTERS-1:0] letter,
    input  logic                         nucleotide_mode,
    output accm_pkg::accm_groups_t       groups
);

    always_comb
    begin
        groups = '0;
        if (nucleotide_mode)
        begin
            groups.strong_set[0] = |(letter & accm_pkg::NUC_TU);
            groups.weak_set[0]   = |(letter & accm_pkg::NUC_AG);
            groups.weak_set[1]   = |(letter & accm_pkg::NUC_CT);
        end
        else
        begin
            for (int k = 0; k < accm_pkg::STRONG_GROUPS; k++)
            begin
                groups.strong_set[k] = |(letter & accm_pkg::PROT_STRONG[k]);
            end
            for (int k = 0; k < accm_pkg::WEAK_GROUPS; k++)
            begin
                groups.weak_set[k] = |(letter & accm_pkg::PROT_WEAK[k]);
            end
        end
    end

endmodule

>>> sv/alignment_column_conservation_mark_unit.sv
// A residue request is registered in the input register, then processed from there; the mark of a
// column is registered in the output register when its last-row request moves on.
// Throughput: one residue per cycle while no last-row request waits behind a held mark.
// The input takes requests while a mark waits, unless the held request closes a column.
// Reset (rst_n low, asynchronous) clears the channels, opens a new column and
// restores the configuration registers to their reset values.
module alignment_column_conservation_mark_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [25:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] residue
    input  logic        s_tlast,   // last_in_column
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] mark_code, [7:2] zero
);

    logic                         nucleotide_mode_reg;
    logic                         extended_alphabet_reg;
    logic [accm_pkg::LETTERS-1:0] valid_letter_mask_reg;

    logic       in_valid_reg;
    logic [7:0] residue_reg;
    logic       last_reg;
    logic       advance;

    logic                               at_column_start_reg;
    logic [7:0]                         first_residue_reg;
    logic [7:0]                         first_residue_next;
    logic                               gap_seen_reg;
    logic                               gap_seen_next;
    logic                               first_invalid_reg;
    logic                               first_invalid_next;
    logic                               all_identical_reg;
    logic                               all_identical_next;
    logic [accm_pkg::STRONG_GROUPS-1:0] strong_hits_reg;
    logic [accm_pkg::STRONG_GROUPS-1:0] strong_hits_next;
    logic [accm_pkg::WEAK_GROUPS-1:0]   weak_hits_reg;
    logic [accm_pkg::WEAK_GROUPS-1:0]   weak_hits_next;

    logic [7:0]                   upper;
    logic [accm_pkg::LETTERS-1:0] letter;
    logic                         same_residue;
    accm_pkg::accm_groups_t       groups;
    accm_pkg::mark_t              mark_next;

    logic            out_valid_reg;
    accm_pkg::mark_t mark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nucleotide_mode_reg   <= 1'b0;
            extended_alphabet_reg <= 1'b0;
            valid_letter_mask_reg <= accm_pkg::VALID_MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (accm_pkg::cfg_index_t'(cfg_index))
                accm_pkg::CFG_NUCLEOTIDE_MODE:   nucleotide_mode_reg   <= cfg_data[0];
                accm_pkg::CFG_EXTENDED_ALPHABET: extended_alphabet_reg <= cfg_data[0];
                accm_pkg::CFG_VALID_LETTER_MASK: valid_letter_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A last-row request moves on only when the output register is free or draining.
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign upper  = accm_pkg::fold_upper(residue_reg);
    assign letter = accm_pkg::letter_onehot(upper);

    accm_group_lookup u_group_lookup
    (
        .letter          (letter),
        .nucleotide_mode (nucleotide_mode_reg),
        .groups          (groups)
    );

    always_comb
    begin
        first_residue_next = at_column_start_reg ? residue_reg : first_residue_reg;
        first_invalid_next = at_column_start_reg ? !(|(letter & valid_letter_mask_reg))
                                                 : first_invalid_reg;
        gap_seen_next = (gap_seen_reg && !at_column_start_reg)
                        || residue_reg == accm_pkg::CHAR_GAP
                        || residue_reg == accm_pkg::CHAR_SPACE;
        if (extended_alphabet_reg)
        begin
            same_residue = residue_reg == first_residue_next;
        end
        else
        begin
            same_residue = upper == accm_pkg::fold_upper(first_residue_next);
        end
        all_identical_next = (all_identical_reg || at_column_start_reg) && same_residue;
        strong_hits_next = (at_column_start_reg ? '1 : strong_hits_reg) & groups.strong_set;
        weak_hits_next   = (at_column_start_reg ? '1 : weak_hits_reg) & groups.weak_set;

        if (gap_seen_next || first_invalid_next)
        begin
            mark_next = accm_pkg::MARK_BLANK;
        end
        else if (all_identical_next)
        begin
            mark_next = accm_pkg::MARK_STAR;
        end
        else if (extended_alphabet_reg)
        begin
            mark_next = accm_pkg::MARK_BLANK;
        end
        else if (|strong_hits_next)
        begin
            mark_next = accm_pkg::MARK_COLON;
        end
        else if (|weak_hits_next)
        begin
            mark_next = accm_pkg::MARK_DOT;
        end
        else
        begin
            mark_next = accm_pkg::MARK_BLANK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            at_column_start_reg <= 1'b1;
            gap_seen_reg        <= 1'b0;
            first_invalid_reg   <= 1'b0;
            all_identical_reg   <= 1'b1;
            strong_hits_reg     <= '1;
            weak_hits_reg       <= '1;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                at_column_start_reg <= last_reg;
                gap_seen_reg        <= gap_seen_next;
                first_invalid_reg   <= first_invalid_next;
                all_identical_reg   <= all_identical_next;
                strong_hits_reg     <= strong_hits_next;
                weak_hits_reg       <= weak_hits_next;
            end
            if (advance && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            residue_reg <= s_tdata;
            last_reg    <= s_tlast;
        end
        if (advance)
        begin
            first_residue_reg <= first_residue_next;
        end
        if (advance && last_reg)
        begin
            mark_reg <= mark_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, mark_reg};

endmodule

>>> sv/accm_checker.sv
// Port-level checker for the column conservation mark unit, bound to the top level.
// Depends on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"

module accm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    logic       last_req;
    logic       mark_req;
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    assign last_req = s_tvalid && s_tready && s_tlast;
    assign mark_req = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (last_req && !mark_req)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (mark_req && !last_req)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Every mark answers a last-row request that came before it.
    `ASSERT_IMPLY(mark_follows_last, clk, rst_n, mark_req, pending_reg != 2'd0)
    // At most one column in the input register and one in the output register.
    `ASSERT_ALWAYS(pending_bounded, clk, rst_n, pending_reg != 2'd3)
    // The input stalls only behind a mark that the sink holds back.
    `ASSERT_IMPLY(stall_only_on_backlog, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    `ASSERT_NEXT(mark_held, clk, rst_n, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata))

endmodule

bind alignment_column_conservation_mark_unit accm_checker u_accm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
